// File: rtl/polyphase_fir_resampler_core_defines.svh
// Assertion macros shared by the resampler RTL.
`ifndef POLYPHASE_FIR_RESAMPLER_CORE_DEFINES_SVH
`define POLYPHASE_FIR_RESAMPLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PFR_ASSERT_IMPL(lbl, clk_i, rstn_i, pre, post) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |-> (post)) \
		else $error("pfr assertion failed");
// Next-cycle implication.
`define PFR_ASSERT_NEXT(lbl, clk_i, rstn_i, pre, post) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |=> (post)) \
		else $error("pfr assertion failed");
`else
`define PFR_ASSERT_IMPL(lbl, clk_i, rstn_i, pre, post)
`define PFR_ASSERT_NEXT(lbl, clk_i, rstn_i, pre, post)
`endif
`endif

// File: rtl/pfr_pkg.sv
// Shared constants, codes and controller/datapath types of the resampler.
package pfr_pkg;

	localparam int HISTORY_DEPTH  = 512;
	localparam int TAPS_PER_DECIM = 31;
	localparam int MAX_INTERP     = 16;
	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_WIDTH     = 18;
	localparam int MAX_DECIM      = 16;
	localparam int COEF_DEPTH     = 512;
	localparam int COEF_AW        = 9;
	localparam int FACTOR_W       = 5;
	localparam int PHASE_W        = 6;
	localparam int CFG_IDX_W      = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERP = 1'b0,
		REG_DECIM  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_COEF   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAPS,
		ST_DRAIN,
		ST_SCALE,
		ST_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic coef_wr;
		logic hist_wr;
		logic start_out;
		logic issue_tap;
		logic scale;
		logic emit;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic phase_below_l;
		logic tap_in_range;
		logic tap_last;
		logic pipe_busy;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/pfr_if.sv
// Valid/ready channel interfaces for input items and result items.
interface pfr_in_if #(
	parameter int SAMPLE_WIDTH = pfr_pkg::SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = pfr_pkg::COEF_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [pfr_pkg::COEF_AW-1:0]    coef_index;
	logic signed [COEF_WIDTH-1:0]   coef_value;
	logic signed [SAMPLE_WIDTH-1:0] sample_re;
	logic signed [SAMPLE_WIDTH-1:0] sample_im;

	modport source (output valid, kind, coef_index, coef_value, sample_re, sample_im,
		input ready);
	modport sink (input valid, kind, coef_index, coef_value, sample_re, sample_im,
		output ready);
endinterface

interface pfr_out_if #(
	parameter int SAMPLE_WIDTH = pfr_pkg::SAMPLE_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_re;
	logic signed [SAMPLE_WIDTH-1:0] out_im;
	logic                           last_of_run;

	modport source (output valid, out_re, out_im, last_of_run, input ready);
	modport sink (input valid, out_re, out_im, last_of_run, output ready);
endinterface

// File: rtl/pfr_ctrl.sv
// Controller state machine that sequences one input item through the datapath.
module pfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             kind,
	input  pfr_pkg::dp_sts_t sts,
	output pfr_pkg::dp_cmd_t cmd,
	output logic             in_ready
);

	pfr_pkg::ctrl_state_t state_q;
	pfr_pkg::ctrl_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			pfr_pkg::ST_IDLE: begin
				if (accept && kind == pfr_pkg::KIND_SAMPLE) begin
					state_next = pfr_pkg::ST_CHECK;
				end
			end
			pfr_pkg::ST_CHECK: begin
				state_next = sts.phase_below_l ? pfr_pkg::ST_TAPS : pfr_pkg::ST_IDLE;
			end
			pfr_pkg::ST_TAPS: begin
				if (!sts.tap_in_range || sts.tap_last) begin
					state_next = pfr_pkg::ST_DRAIN;
				end
			end
			pfr_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_next = pfr_pkg::ST_SCALE;
				end
			end
			pfr_pkg::ST_SCALE: begin
				state_next = pfr_pkg::ST_EMIT;
			end
			pfr_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					state_next = pfr_pkg::ST_CHECK;
				end
			end
			default: begin
				state_next = pfr_pkg::ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pfr_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.coef_wr = accept && kind == pfr_pkg::KIND_COEF;
				cmd.hist_wr = accept && kind == pfr_pkg::KIND_SAMPLE;
			end
			pfr_pkg::ST_CHECK: begin
				cmd.start_out = sts.phase_below_l;
				cmd.finish    = !sts.phase_below_l;
			end
			pfr_pkg::ST_TAPS: begin
				cmd.issue_tap = sts.tap_in_range;
			end
			pfr_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			pfr_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
			end
			pfr_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/pfr_datapath.sv
// Datapath: factor registers, coefficient and history memories, the shared MAC and output register.
`include "polyphase_fir_resampler_core_defines.svh"
module pfr_datapath #(
	parameter int HISTORY_DEPTH  = pfr_pkg::HISTORY_DEPTH,
	parameter int TAPS_PER_DECIM = pfr_pkg::TAPS_PER_DECIM,
	parameter int MAX_INTERP     = pfr_pkg::MAX_INTERP,
	parameter int SAMPLE_WIDTH   = pfr_pkg::SAMPLE_WIDTH,
	parameter int COEF_WIDTH     = pfr_pkg::COEF_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfr_pkg::FACTOR_W-1:0]        cfg_data,
	input  pfr_pkg::dp_cmd_t                    cmd,
	output pfr_pkg::dp_sts_t                    sts,
	input  logic [pfr_pkg::COEF_AW-1:0]         coef_index,
	input  logic signed [COEF_WIDTH-1:0]        coef_value,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_im,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]      out_re,
	output logic signed [SAMPLE_WIDTH-1:0]      out_im,
	output logic                                out_last
);

	localparam int HAW      = $clog2(HISTORY_DEPTH);
	localparam int FW       = $clog2(HISTORY_DEPTH + 1);
	localparam int LW       = $clog2(MAX_INTERP + 1);
	localparam int MW       = $clog2(pfr_pkg::MAX_DECIM + 1);
	localparam int NFLT_MAX = TAPS_PER_DECIM * pfr_pkg::MAX_DECIM;
	localparam int KW0      = $clog2(NFLT_MAX + MAX_INTERP + 1);
	localparam int KW       = (KW0 > pfr_pkg::COEF_AW) ? KW0 : pfr_pkg::COEF_AW;
	localparam int PW2      = (pfr_pkg::PHASE_W + 1 > LW) ? pfr_pkg::PHASE_W + 1 : LW;
	localparam int PW       = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W    = PW + $clog2(NFLT_MAX);
	localparam int SC_W     = ACC_W + LW + 1;
	localparam int SH       = COEF_WIDTH - 1;

	// Clamped factors and filter length.
	logic [LW-1:0]                  l_q, l_next;
	logic [MW-1:0]                  m_q, m_next;
	logic [KW-1:0]                  nflt_q;

	// Sequencing state.
	logic [HAW-1:0]                 wi_q;
	logic [FW-1:0]                  fill_q;
	logic [pfr_pkg::PHASE_W-1:0]    phase_q;
	logic [KW-1:0]                  k_q;
	logic [HAW-1:0]                 j_q;
	logic [PW2-1:0]                 phase_sum;
	logic                           hist_ok;

	// Memories.
	logic signed [COEF_WIDTH-1:0]   coef_mem [pfr_pkg::COEF_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] hist_re_mem [HISTORY_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] hist_im_mem [HISTORY_DEPTH];

	// MAC pipeline.
	logic                           v_s1, vd_s1, v_s2;
	logic signed [COEF_WIDTH-1:0]   coef_s1;
	logic signed [SAMPLE_WIDTH-1:0] hre_s1, him_s1;
	logic signed [PW-1:0]           prod_re_s2, prod_im_s2;
	logic signed [ACC_W-1:0]        acc_re_q, acc_im_q;
	logic signed [SC_W-1:0]         scaled_re_q, scaled_im_q;

	// Output register.
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_re_q, out_im_q;
	logic                           out_last_q;
	logic                           out_free;

	// Round half up, drop the coefficient fraction and saturate.
	function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [SC_W-1:0] v);
		logic signed [SC_W-1:0] half;
		logic signed [SC_W-1:0] smax;
		logic signed [SC_W-1:0] smin;
		logic signed [SC_W-1:0] q;
		half = SC_W'(1) << (SH - 1);
		smax = SC_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
		smin = -smax - SC_W'(1);
		q    = (v + half) >>> SH;
		if (q > smax) begin
			q = smax;
		end else if (q < smin) begin
			q = smin;
		end
		return q[SAMPLE_WIDTH-1:0];
	endfunction

	// Clamp written factors into their legal ranges.
	always_comb begin
		if (cfg_data == '0) begin
			l_next = LW'(1);
			m_next = MW'(1);
		end else begin
			l_next = (32'(cfg_data) > MAX_INTERP) ? LW'(MAX_INTERP) : LW'(cfg_data);
			m_next = (32'(cfg_data) > pfr_pkg::MAX_DECIM) ? MW'(pfr_pkg::MAX_DECIM) :
				MW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q    <= LW'(1);
			m_q    <= MW'(1);
			nflt_q <= KW'(TAPS_PER_DECIM);
		end else if (cfg_we) begin
			if (cfg_index == pfr_pkg::REG_INTERP) begin
				l_q <= l_next;
			end else if (cfg_index == pfr_pkg::REG_DECIM) begin
				m_q    <= m_next;
				nflt_q <= KW'(KW'(TAPS_PER_DECIM) * KW'(m_next));
			end
		end
	end

	// Coefficient and history memories with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.coef_wr) begin
			coef_mem[coef_index] <= coef_value;
		end
		if (cmd.hist_wr) begin
			hist_re_mem[wi_q] <= sample_re;
			hist_im_mem[wi_q] <= sample_im;
		end
		if (cmd.issue_tap) begin
			coef_s1 <= coef_mem[k_q[pfr_pkg::COEF_AW-1:0]];
			hre_s1  <= hist_re_mem[j_q];
			him_s1  <= hist_im_mem[j_q];
		end
	end

	// History entries never written read as zero.
	assign hist_ok   = (fill_q == FW'(HISTORY_DEPTH)) || (FW'(j_q) < fill_q);
	assign phase_sum = PW2'(phase_q) + PW2'(m_q);
	assign out_free  = !out_valid_q || out_ready;

	// Write index, fill count, phase and tap counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q    <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.hist_wr && fill_q != FW'(HISTORY_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.start_out) begin
				k_q <= KW'(phase_q);
				j_q <= wi_q;
			end else if (cmd.issue_tap) begin
				k_q <= k_q + KW'(l_q);
				j_q <= (j_q == '0) ? HAW'(HISTORY_DEPTH - 1) : j_q - 1'b1;
			end
			if (cmd.emit) begin
				phase_q <= phase_sum[pfr_pkg::PHASE_W-1:0];
			end else if (cmd.finish) begin
				phase_q <= phase_q - pfr_pkg::PHASE_W'(l_q);
				wi_q    <= (wi_q == HAW'(HISTORY_DEPTH - 1)) ? '0 : wi_q + 1'b1;
			end
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			vd_s1 <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1  <= cmd.issue_tap;
			vd_s1 <= hist_ok;
			v_s2  <= v_s1;
		end
	end

	// Complex multiply by a real tap, accumulate, then scale by L.
	always_ff @(posedge clk) begin
		if (vd_s1) begin
			prod_re_s2 <= coef_s1 * hre_s1;
			prod_im_s2 <= coef_s1 * him_s1;
		end else begin
			prod_re_s2 <= '0;
			prod_im_s2 <= '0;
		end
		if (cmd.start_out) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(prod_re_s2);
			acc_im_q <= acc_im_q + ACC_W'(prod_im_s2);
		end
		if (cmd.scale) begin
			scaled_re_q <= acc_re_q * $signed({1'b0, l_q});
			scaled_im_q <= acc_im_q * $signed({1'b0, l_q});
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_re_q   <= round_sat(scaled_re_q);
			out_im_q   <= round_sat(scaled_im_q);
			out_last_q <= phase_sum >= PW2'(l_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign out_last  = out_last_q;

	// Status to the controller.
	always_comb begin
		sts.phase_below_l = PW2'(phase_q) < PW2'(l_q);
		sts.tap_in_range  = k_q < nflt_q;
		sts.tap_last      = ((KW+1)'(k_q) + (KW+1)'(l_q)) >= (KW+1)'(nflt_q);
		sts.pipe_busy     = v_s1 || v_s2;
		sts.out_free      = out_free;
	end

	// A waiting result is never overwritten.
	`PFR_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, out_free)
	// Scaling only starts once every product has been accumulated.
	`PFR_ASSERT_IMPL(a_scale_drained, clk, arst_n, cmd.scale, !(v_s1 || v_s2))
	// An output is only produced while the phase is below L.
	`PFR_ASSERT_IMPL(a_emit_phase, clk, arst_n, cmd.emit, sts.phase_below_l)
	// After a sample is stored the history is never empty.
	`PFR_ASSERT_NEXT(a_fill_nonzero, clk, arst_n, cmd.hist_wr, fill_q != '0)

endmodule

// File: rtl/polyphase_fir_resampler_core.sv
// Polyphase FIR rational resampler (interpolate by L, decimate by M) for complex samples.
// A coefficient item is written to memory as it is accepted. A sample item is stored as it is
// accepted; each output then takes a phase check, one tap per cycle on the single shared
// complex MAC (ceil((TAPS_PER_DECIM*M - phase) / L) taps), a pipeline drain, a scaling step
// and a load of the output register, and a final phase check ends the item. The tap count
// through the one MAC sets the rate, and a full output register holds the sequencer until
// the result is taken. History that was never written reads as zero through a fill count, so
// reset needs no clearing pass. Input is accepted only while the block is idle; the user must
// write configuration only while idle, which the block itself does not enforce.
module polyphase_fir_resampler_core #(
	parameter int HISTORY_DEPTH  = pfr_pkg::HISTORY_DEPTH,
	parameter int TAPS_PER_DECIM = pfr_pkg::TAPS_PER_DECIM,
	parameter int MAX_INTERP     = pfr_pkg::MAX_INTERP,
	parameter int SAMPLE_WIDTH   = pfr_pkg::SAMPLE_WIDTH,
	parameter int COEF_WIDTH     = pfr_pkg::COEF_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfr_pkg::FACTOR_W-1:0]  cfg_data,
	pfr_in_if.sink                        sample_in,
	pfr_out_if.source                     result_out
);

	pfr_pkg::dp_cmd_t cmd;
	pfr_pkg::dp_sts_t sts;
	logic             in_ready;
	logic             accept;

	// Input transfer.
	assign accept          = sample_in.valid && in_ready;
	assign sample_in.ready = in_ready;

	pfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (sample_in.kind),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	pfr_datapath #(
		.HISTORY_DEPTH  (HISTORY_DEPTH),
		.TAPS_PER_DECIM (TAPS_PER_DECIM),
		.MAX_INTERP     (MAX_INTERP),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_WIDTH     (COEF_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.coef_index (sample_in.coef_index),
		.coef_value (sample_in.coef_value),
		.sample_re  (sample_in.sample_re),
		.sample_im  (sample_in.sample_im),
		.out_ready  (result_out.ready),
		.out_valid  (result_out.valid),
		.out_re     (result_out.out_re),
		.out_im     (result_out.out_im),
		.out_last   (result_out.last_of_run)
	);

endmodule
